// ===== hdl/pbcs_pkg.sv =====
`default_nettype none

package pbcs_pkg;

  localparam int unsigned MAX_SERVERS_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam int unsigned PICK_W     = 5;
  localparam int unsigned OUT_IDX_W  = 4;
  localparam int unsigned RANK_W     = 64;
  localparam int unsigned IDENT_W    = 64;
  localparam int unsigned KEY_W      = RANK_W + IDENT_W;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 8;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;    // start of a scan, forget the current best
    logic cand_ok;  // candidate key is valid and not yet picked
  } cmp_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ptp_best_clock_select.sv =====
`default_nettype none
// Loading: s_axis_tready is high in every load cycle.
// Selection after the last candidate: each pick scans the store through the shared
// comparator, one entry per cycle.
// Reset (rst_ni, asynchronous, active low) empties the batch and sets pick_count to 1;
// store contents are not cleared.

module ptp_best_clock_select
  import pbcs_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // priority_one, clock_class, clock_accuracy, clock_variance, priority_two,
  // clock_identity, steps_removed
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tuser,   // entry_valid
  input  wire logic                  s_axis_tlast,   // last_candidate
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // server_index, found, zero pad
  output logic                       m_axis_tlast,   // last_pick
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [PICK_W-1:0]     cfg_data_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SERVERS);
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int unsigned CW    = (CNT_W > PICK_W) ? CNT_W : PICK_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [PICK_W-1:0]      pick_count_q, pick_count_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       vcnt_q, vcnt_d;
  logic [MAX_SERVERS-1:0] valid_q, valid_d;
  logic [MAX_SERVERS-1:0] picked_q, picked_d;
  logic [PICK_W-1:0]      total_q, total_d;
  logic [PICK_W-1:0]      done_q, done_d;
  logic                   none_q, none_d;
  logic [CNT_W-1:0]       rd_addr_q, rd_addr_d;
  logic                   rd_v_q, rd_v_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic                   out_v_q, out_v_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                   out_found_q, out_found_d;
  logic                   out_last_q, out_last_d;

  logic                   in_xact, room, issue, out_free, put_last;
  logic [PICK_W-1:0]      limit;
  logic [CW-1:0]          vcnt_ext;
  logic [RANK_W-1:0]      wr_rank;
  logic [KEY_W-1:0]       rd_key;
  logic                   take;
  cmp_ctl_t               cmp_ctl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign room          = (cnt_q < CNT_W'(MAX_SERVERS));
  assign issue         = (state_q == ST_SCAN) && (rd_addr_q != cnt_q);
  assign out_free      = !out_v_q || m_axis_tready;
  assign put_last      = none_q || (PICK_W'(done_q + 1'b1) == total_q);
  assign limit         = (pick_count_q > PICK_W'(MAX_RESULTS)) ? PICK_W'(MAX_RESULTS)
                                                                : pick_count_q;

  assign wr_rank = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                    s_axis_tdata[39:24], s_axis_tdata[47:40], s_axis_tdata[127:112]};

  pbcs_store #(
    .DEPTH (MAX_SERVERS),
    .AW    (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (in_xact && room),
    .wr_addr_i  (cnt_q[IDX_W-1:0]),
    .wr_rank_i  (wr_rank),
    .wr_ident_i (s_axis_tdata[111:48]),
    .rd_en_i    (issue),
    .rd_addr_i  (rd_addr_q[IDX_W-1:0]),
    .rd_key_o   (rd_key)
  );

  always_comb begin
    cmp_ctl.clear   = 1'b0;
    cmp_ctl.cand_ok = rd_v_q && valid_q[rd_idx_q] && !picked_q[rd_idx_q];
    if (state_d == ST_SCAN && state_q != ST_SCAN) begin
      cmp_ctl.clear = 1'b1;
    end
  end

  pbcs_cmp u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cmp_ctl),
    .cand_key_i (rd_key),
    .take_o     (take)
  );

  always_comb begin
    state_d      = state_q;
    pick_count_d = pick_count_q;
    cnt_d        = cnt_q;
    vcnt_d       = vcnt_q;
    valid_d      = valid_q;
    picked_d     = picked_q;
    total_d      = total_q;
    done_d       = done_q;
    none_d       = none_q;
    rd_addr_d    = rd_addr_q;
    rd_v_d       = 1'b0;
    rd_idx_d     = rd_addr_q[IDX_W-1:0];
    best_idx_d   = take ? rd_idx_q : best_idx_q;
    out_v_d      = out_v_q && !m_axis_tready;
    out_idx_d    = out_idx_q;
    out_found_d  = out_found_q;
    out_last_d   = out_last_q;
    vcnt_ext     = CW'(vcnt_q);

    if (cfg_valid_i) begin
      pick_count_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xact) begin
          if (room) begin
            valid_d[cnt_q[IDX_W-1:0]] = s_axis_tuser;
            cnt_d  = CNT_W'(cnt_q + 1'b1);
            vcnt_d = CNT_W'(vcnt_q + CNT_W'(s_axis_tuser));
          end
          vcnt_ext = CW'(vcnt_d);
          if (s_axis_tlast) begin
            total_d   = (vcnt_ext < CW'(limit)) ? PICK_W'(vcnt_ext) : limit;
            done_d    = '0;
            rd_addr_d = '0;
            if (total_d == '0) begin
              none_d  = 1'b1;
              state_d = ST_PUT;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_addr_d = CNT_W'(rd_addr_q + 1'b1);
          rd_v_d    = 1'b1;
        end else if (!rd_v_q) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_idx_d   = none_q ? '0 : OUT_IDX_W'(best_idx_q);
          out_found_d = !none_q;
          out_last_d  = put_last;
          if (put_last) begin
            cnt_d    = '0;
            vcnt_d   = '0;
            valid_d  = '0;
            picked_d = '0;
            none_d   = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            picked_d[best_idx_q] = 1'b1;
            done_d    = PICK_W'(done_q + 1'b1);
            rd_addr_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pick_count_q <= PICK_W'(1);
      cnt_q        <= '0;
      vcnt_q       <= '0;
      valid_q      <= '0;
      picked_q     <= '0;
      total_q      <= '0;
      done_q       <= '0;
      none_q       <= 1'b0;
      rd_addr_q    <= '0;
      rd_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      pick_count_q <= pick_count_d;
      cnt_q        <= cnt_d;
      vcnt_q       <= vcnt_d;
      valid_q      <= valid_d;
      picked_q     <= picked_d;
      total_q      <= total_d;
      done_q       <= done_d;
      none_q       <= none_d;
      rd_addr_q    <= rd_addr_d;
      rd_v_q       <= rd_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_IDX_W - 1){1'b0}}, out_found_q, out_idx_q};

`ifndef NO_ASSERTIONS
  a_pick_eligible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT && out_free && !none_q)
      |-> (valid_q[best_idx_q] && !picked_q[best_idx_q]))
    else $error("picked entry is not valid or already picked");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(MAX_SERVERS)) && (vcnt_q <= cnt_q))
    else $error("load counters out of range");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (done_q < total_q || none_q))
    else $error("pick count ran past batch total");
`endif

endmodule

`default_nettype wire

// ===== hdl/pbcs_store.sv =====
`default_nettype none

module pbcs_store
  import pbcs_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_SERVERS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire logic [RANK_W-1:0]  wr_rank_i,
  input  wire logic [IDENT_W-1:0] wr_ident_i,
  input  wire logic               rd_en_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  output logic      [KEY_W-1:0]   rd_key_o
);

  logic [RANK_W-1:0]  rank_mem  [DEPTH];
  logic [IDENT_W-1:0] ident_mem [DEPTH];
  logic [RANK_W-1:0]  rank_q;
  logic [IDENT_W-1:0] ident_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rank_mem[wr_addr_i]  <= wr_rank_i;
      ident_mem[wr_addr_i] <= wr_ident_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rank_q  <= rank_mem[rd_addr_i];
      ident_q <= ident_mem[rd_addr_i];
    end
  end

  // sort key: rank fields above the identity, steps removed as final tie breaker
  assign rd_key_o = {rank_q[RANK_W-1:16], ident_q, rank_q[15:0]};

endmodule

`default_nettype wire

// ===== hdl/pbcs_cmp.sv =====
`default_nettype none

module pbcs_cmp
  import pbcs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmp_ctl_t         ctl_i,
  input  wire logic [KEY_W-1:0] cand_key_i,
  output logic                  take_o
);

  logic             have_q, have_d;
  logic [KEY_W-1:0] best_key_q, best_key_d;

  // strict less-than keeps the earlier index on a full tie
  assign take_o = ctl_i.cand_ok && (!have_q || (cand_key_i < best_key_q));

  always_comb begin
    have_d     = have_q;
    best_key_d = best_key_q;
    if (ctl_i.clear) begin
      have_d = 1'b0;
    end else if (take_o) begin
      have_d     = 1'b1;
      best_key_d = cand_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import pbcs_pkg::*;

  localparam int unsigned SLOTS = MAX_SERVERS_DEF;

  typedef struct {
    logic        entry_ok;
    logic [7:0]  prio1;
    logic [7:0]  clk_class;
    logic [7:0]  clk_acc;
    logic [15:0] clk_var;
    logic [7:0]  prio2;
    logic [63:0] ident;
    logic [15:0] steps;
    logic        batch_end;
  } cand_t;

  typedef struct {
    logic [3:0] srv_idx;
    logic       found;
    logic       last_pick;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_DATA_W-1:0]  s_data = '0;
  logic                  s_user = 1'b0;
  logic                  s_last = 1'b0;
  logic                  s_valid = 1'b0;
  wire                   s_ready;
  wire [OUT_DATA_W-1:0]  m_data;
  wire                   m_last;
  wire                   m_valid;
  logic                  m_ready = 1'b0;
  logic [PICK_W-1:0]     cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;

  ptp_best_clock_select dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .s_axis_tlast (s_last),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .cfg_data_i   (cfg_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #(12 * 400000);
    $display("** ptp_best_clock_select: FAILED **");
    $finish;
  end

  cand_t cand_fifo[$];
  pick_t best_picks[$];
  cand_t cur;
  logic  in_taken = 1'b0;
  logic  calm = 1'b0;
  int    mismatches = 0;

  // shadow of the selector state
  logic [127:0] slot_key[SLOTS];
  logic         slot_ok[SLOTS];
  int unsigned  n_loaded = 0;
  int unsigned  pick_cfg = 1;

  function automatic void queue_cand(cand_t c);
    cand_fifo.insert(cand_fifo.size(), c);
  endfunction

  function automatic void queue_pick(pick_t p);
    best_picks.insert(best_picks.size(), p);
  endfunction

  // lexicographic order of the dataset fields equals unsigned order of this key
  function automatic logic [127:0] rank_key(cand_t c);
    return {c.prio1, c.clk_class, c.clk_acc, c.clk_var, c.prio2, c.ident, c.steps};
  endfunction

  task automatic select_best_servers(input cand_t c);
    pick_t       picks[MAX_RESULTS];
    logic        taken[SLOTS];
    int unsigned limit, n, best;
    logic        have;
    for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
    if (n_loaded < SLOTS) begin
      slot_key[n_loaded] = rank_key(c);
      slot_ok[n_loaded] = c.entry_ok;
      n_loaded++;
    end
    if (c.batch_end) begin
      limit = (pick_cfg > MAX_RESULTS) ? MAX_RESULTS : pick_cfg;
      n = 0;
      while (n < limit) begin
        have = 1'b0;
        best = 0;
        for (int unsigned i = 0; i < n_loaded; i++) begin
          // strict compare keeps the lower index on a full tie
          if (slot_ok[i] && !taken[i] && (!have || slot_key[i] < slot_key[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        if (!have) break;
        taken[best] = 1'b1;
        picks[n] = '{srv_idx: best[3:0], found: 1'b1, last_pick: 1'b0};
        n++;
      end
      if (n == 0) begin
        queue_pick('{srv_idx: 4'd0, found: 1'b0, last_pick: 1'b1});
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          picks[i].last_pick = (i == n - 1);
          queue_pick(picks[i]);
        end
      end
      n_loaded = 0;
      for (int i = 0; i < SLOTS; i++) slot_ok[i] = 1'b0;
    end
  endtask

  // driver: one candidate transaction at a time, held until accepted
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (cand_fifo.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
        cur = cand_fifo.pop_front();
        s_data <= {cur.steps, cur.ident, cur.prio2, cur.clk_var,
                   cur.clk_acc, cur.clk_class, cur.prio1};
        s_user <= cur.entry_ok;
        s_last <= cur.batch_end;
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= calm || ($urandom_range(99) >= 30);
  end

  // monitor
  always @(posedge clk_i) begin
    pick_t want;
    in_taken <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) select_best_servers(cur);
    if (rst_ni && m_valid && m_ready) begin
      if (best_picks.size() == 0) begin
        $display("%0t: unexpected pick: idx %0d found %0b last %0b", $realtime,
                 m_data[3:0], m_data[4], m_last);
        mismatches++;
      end else begin
        want = best_picks.pop_front();
        if (m_data[3:0] !== want.srv_idx || m_data[4] !== want.found ||
            m_last !== want.last_pick) begin
          // fields shown as idx/found/last
          $display("%0t: pick mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   $realtime, want.srv_idx, want.found, want.last_pick,
                   m_data[3:0], m_data[4], m_last);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (cand_fifo.size() != 0 || s_valid || best_picks.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pick_count(input logic [PICK_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready);
    pick_cfg = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic cand_t mk(logic ok, logic [7:0] p1, logic [7:0] cls, logic [7:0] acc,
                               logic [15:0] vr, logic [7:0] p2, logic [63:0] id,
                               logic [15:0] st, logic fin);
    return '{entry_ok: ok, prio1: p1, clk_class: cls, clk_acc: acc, clk_var: vr,
             prio2: p2, ident: id, steps: st, batch_end: fin};
  endfunction

  // keep a field at the batch base, nudge it, squash it or randomize it, so ties happen
  function automatic logic [63:0] vary(logic [63:0] b, int unsigned w);
    logic [63:0] m;
    logic [63:0] r;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: vary = b & m;
      1: vary = (b + 64'd1) & m;
      2: vary = 64'($urandom_range(1));
      default: vary = r & m;
    endcase
  endfunction

  function automatic cand_t rand_cand(cand_t base, logic ok, logic fin);
    cand_t c;
    c.prio1 = 8'(vary(base.prio1, 8));
    c.clk_class = 8'(vary(base.clk_class, 8));
    c.clk_acc = 8'(vary(base.clk_acc, 8));
    c.clk_var = 16'(vary(base.clk_var, 16));
    c.prio2 = 8'(vary(base.prio2, 8));
    c.ident = vary(base.ident, 64);
    c.steps = 16'(vary(base.steps, 16));
    c.entry_ok = ok;
    c.batch_end = fin;
    return c;
  endfunction

  initial begin
    logic [PICK_W-1:0] phase_picks[10];
    cand_t       base;
    int unsigned phase_items, bsize, sel;
    logic        dead_batch;

    phase_picks = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd7, 5'd17, 5'd16, 5'd3};
    for (int i = 0; i < SLOTS; i++) slot_ok[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset pick count of one
    queue_cand(mk(1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 64'h0, 16'h0000, 1'b1));
    queue_cand(mk(1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, '1, 16'hFFFF, 1'b1));
    write_pick_count(5'd16);
    // identical datasets: lower index first
    for (int i = 0; i < 3; i++)
      queue_cand(mk(1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, '1, 16'hFFFF, i == 2));
    // store overflow: the 17th (best of all) is dropped but still closes the batch
    for (int i = 0; i < 16; i++)
      queue_cand(mk(i % 5 != 3, 8'd128 - 8'(i % 4), 8'd6, 8'h21, 16'h4E5D, 8'd128,
                    64'h0011_22FF_FE33_4455 ^ 64'(i % 3), 16'(i % 2), 1'b0));
    queue_cand(mk(1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 64'h0, 16'h0000, 1'b1));
    write_pick_count(5'd0);
    queue_cand(mk(1'b1, 8'd1, 8'd2, 8'd3, 16'd4, 8'd5, 64'd6, 16'd7, 1'b1));

    // random batches, one pick count per phase
    foreach (phase_picks[p]) begin
      write_pick_count(phase_picks[p]);
      calm = (p == 2);
      phase_items = 0;
      while (phase_items < 35) begin
        sel = $urandom_range(9);
        bsize = (sel < 7) ? $urandom_range(8, 1) :
                (sel < 9) ? $urandom_range(16, 9) : $urandom_range(20, 17);
        dead_batch = ($urandom_range(11) == 0);
        base = rand_cand(mk(1'b1, 8'd128, 8'd248, 8'hFE, 16'hFFFF, 8'd128,
                            {$urandom, $urandom}, 16'd0, 1'b0), 1'b1, 1'b0);
        for (int unsigned k = 0; k < bsize; k++)
          queue_cand(rand_cand(base, !dead_batch && $urandom_range(9) < 8,
                               k == bsize - 1));
        phase_items += bsize;
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** ptp_best_clock_select: PASSED **");
    end else begin
      $display("** ptp_best_clock_select: FAILED **");
    end
    $finish;
  end

endmodule

// ===== ptp_best_clock_select.f =====
hdl/pbcs_pkg.sv
hdl/pbcs_store.sv
hdl/pbcs_cmp.sv
hdl/ptp_best_clock_select.sv
test/testbench.sv
